@@ rtl/core/n2a_pkg.sv @@
// ----------------------------------------------------------------------------
// n2a_pkg: shared types and constants for number_to_ascii_digits
// Beat structs for both channels, mode codes, character codes and the
// control group that drives the row of BCD cells.
// ----------------------------------------------------------------------------
package n2a_pkg;

    // Mode codes
    localparam logic [1:0] FUNC_UDEC = 2'd0;
    localparam logic [1:0] FUNC_SDEC = 2'd1;
    localparam logic [1:0] FUNC_HEX  = 2'd2;
    localparam logic [1:0] FUNC_BIN  = 2'd3;

    // Number width and length of the BCD cell row
    localparam int NUM_BITS = 32;
    localparam int N_DIGITS = 10;

    // Digit count limits per radix
    localparam logic [5:0] MAX_DEC = 6'd10;
    localparam logic [5:0] MAX_HEX = 6'd8;
    localparam logic [5:0] MAX_BIN = 6'd32;

    // Character codes
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_UPPER = 7'h41;
    localparam logic [6:0] CHAR_PLUS  = 7'h2B;
    localparam logic [6:0] CHAR_MINUS = 7'h2D;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] number;
        logic [5:0]  digit_count;
        logic [2:0]  text_line;
        logic [4:0]  start_column;
    } t_in_beat;

    typedef struct packed {
        logic [2:0] out_line;
        logic [5:0] out_column;
        logic [6:0] char_code;
        logic       last;
    } t_out_beat;

    // Control shared by all BCD cells
    typedef struct packed {
        logic clear;
        logic shift;
    } t_cell_ctrl;

endpackage

@@ rtl/core/n2a_bcd_cell.sv @@
// ----------------------------------------------------------------------------
// n2a_bcd_cell: one decimal digit of the shift-add-3 converter
// Holds a BCD digit; each shift cycle it corrects the digit (add 3 when
// five or more), shifts in the carry from the lower neighbor and passes
// its top bit to the upper neighbor.
// ----------------------------------------------------------------------------
module n2a_bcd_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  n2a_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_carry,
    output logic                o_carry,
    output logic [3:0]          o_digit
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] w_adj;

    // Correct the digit before it doubles
    assign w_adj   = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
    assign o_carry = w_adj[3];
    assign o_digit = r_digit;

    // Clear on a new number, shift while converting, else hold
    always_comb begin
        n_digit = r_digit;
        if (i_ctrl.clear) begin
            n_digit = 4'd0;
        end else if (i_ctrl.shift) begin
            n_digit = {w_adj[2:0], i_carry};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit <= 4'd0;
        end else begin
            r_digit <= n_digit;
        end
    end

endmodule

@@ rtl/core/number_to_ascii_digits.sv @@
// ----------------------------------------------------------------------------
// number_to_ascii_digits: 32-bit number to a run of placed ASCII characters
// Unsigned/signed decimal, uppercase hex or binary; digits most significant
// first, zero-padded or cut to digit_count, one output beat per character.
//
//   channel | dir | handshake             | payload
//   in      | in  | i_in_valid/o_in_stall | i_in_beat  (n2a_pkg::t_in_beat)
//   out     | out | o_out_valid/i_out_stall | o_out_beat (n2a_pkg::t_out_beat)
//
// One number at a time. Decimal modes run the value through a row of ten
// BCD cells, one bit a cycle, then emit the characters (count, plus one
// for the sign). Hex and binary go straight to output. Input is taken
// again once the last character is in the output register. Reset is
// synchronous; output stalls hold the character register and pause emission.
// ----------------------------------------------------------------------------
module number_to_ascii_digits (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  n2a_pkg::t_in_beat   i_in_beat,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output n2a_pkg::t_out_beat  o_out_beat,
    input  logic                i_out_stall
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

    t_state             r_state;
    logic [1:0]         r_func;
    logic [31:0]        r_num;
    logic               r_sign_pend;
    logic               r_neg;
    logic [2:0]         r_line;
    logic [5:0]         r_col;
    logic [4:0]         r_pos;
    logic [4:0]         r_cnt;
    logic               r_out_valid;
    n2a_pkg::t_out_beat r_out;

    logic                   w_accept;
    logic                   w_load;
    logic [31:0]            w_mag;
    logic [5:0]             w_maxd;
    logic [5:0]             w_count;
    logic [3:0]             w_nib;
    logic [6:0]             w_char;
    n2a_pkg::t_cell_ctrl    w_ctrl;
    logic [3:0]             w_digit [0:n2a_pkg::N_DIGITS-1];
    logic                   w_carry [0:n2a_pkg::N_DIGITS-2];

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_load     = !r_out_valid || !i_out_stall;

    // Magnitude for signed mode; the most negative value maps onto itself
    assign w_mag = ((i_in_beat.func == n2a_pkg::FUNC_SDEC) && i_in_beat.number[31]) ?
                   (32'd0 - i_in_beat.number) : i_in_beat.number;

    // Clamp the digit count to the radix limit, lift zero to one
    always_comb begin
        case (i_in_beat.func)
            n2a_pkg::FUNC_HEX: w_maxd = n2a_pkg::MAX_HEX;
            n2a_pkg::FUNC_BIN: w_maxd = n2a_pkg::MAX_BIN;
            default:           w_maxd = n2a_pkg::MAX_DEC;
        endcase
        w_count = (i_in_beat.digit_count == 6'd0) ? 6'd1 : i_in_beat.digit_count;
        if (w_count > w_maxd) begin
            w_count = w_maxd;
        end
    end

    // Row of BCD cells, fed from the top bit of the shifting number
    assign w_ctrl.clear = w_accept;
    assign w_ctrl.shift = (r_state == S_CONV);

    for (genvar k = 0; k < n2a_pkg::N_DIGITS; k++) begin : g_cell
        if (k == 0) begin : g_first
            n2a_bcd_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_carry (r_num[31]),
                .o_carry (w_carry[k]),
                .o_digit (w_digit[k])
            );
        end else if (k == n2a_pkg::N_DIGITS - 1) begin : g_top
            n2a_bcd_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_carry (w_carry[k-1]),
                .o_carry (),
                .o_digit (w_digit[k])
            );
        end else begin : g_mid
            n2a_bcd_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_carry (w_carry[k-1]),
                .o_carry (w_carry[k]),
                .o_digit (w_digit[k])
            );
        end
    end

    // Pick the character for the digit at the current position
    assign w_nib = 4'(r_num >> {r_pos[2:0], 2'b00});

    always_comb begin
        case (r_func)
            n2a_pkg::FUNC_HEX: begin
                w_char = (w_nib < 4'd10) ? (n2a_pkg::CHAR_ZERO + 7'(w_nib)) :
                         (n2a_pkg::CHAR_UPPER + 7'(w_nib - 4'd10));
            end
            n2a_pkg::FUNC_BIN: w_char = n2a_pkg::CHAR_ZERO + 7'(r_num[r_pos]);
            default:           w_char = n2a_pkg::CHAR_ZERO + 7'(w_digit[r_pos[3:0]]);
        endcase
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_sign_pend <= 1'b0;
            r_cnt       <= 5'd0;
        end else begin
            // Drop a taken beat when nothing new is loaded
            if (w_load && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_func      <= i_in_beat.func;
                        r_num       <= w_mag;
                        r_neg       <= i_in_beat.number[31];
                        r_sign_pend <= (i_in_beat.func == n2a_pkg::FUNC_SDEC);
                        r_line      <= i_in_beat.text_line;
                        r_col       <= {1'b0, i_in_beat.start_column};
                        r_pos       <= 5'(w_count - 6'd1);
                        r_cnt       <= 5'd0;
                        if (i_in_beat.func == n2a_pkg::FUNC_HEX ||
                            i_in_beat.func == n2a_pkg::FUNC_BIN) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_CONV;
                        end
                    end
                end
                S_CONV: begin
                    // Advance one bit into the cell row
                    r_num <= {r_num[30:0], 1'b0};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(n2a_pkg::NUM_BITS - 1)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_load) begin
                        r_out_valid         <= 1'b1;
                        r_out.out_line      <= r_line;
                        r_out.out_column    <= r_col;
                        r_col               <= r_col + 6'd1;
                        if (r_sign_pend) begin
                            r_sign_pend     <= 1'b0;
                            r_out.char_code <= r_neg ? n2a_pkg::CHAR_MINUS :
                                                       n2a_pkg::CHAR_PLUS;
                            r_out.last      <= 1'b0;
                        end else begin
                            r_out.char_code <= w_char;
                            r_out.last      <= (r_pos == 5'd0);
                            r_pos           <= r_pos - 5'd1;
                            if (r_pos == 5'd0) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

@@ rtl/core/n2a_check.sv @@
// ----------------------------------------------------------------------------
// n2a_check: port-level checks for number_to_ascii_digits
// Watches both channels and flags handshake and sequencing slips.
// ----------------------------------------------------------------------------
module n2a_check (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input n2a_pkg::t_in_beat  i_in_beat,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input n2a_pkg::t_out_beat o_out_beat,
    input logic               i_out_stall
);

    // Hold a stalled output beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("output beat changed under stall");

    // One number at a time: an accepted input closes the input side
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while a number is in progress");

    // A sign character never ends a number
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_beat.char_code == n2a_pkg::CHAR_PLUS ||
                        o_out_beat.char_code == n2a_pkg::CHAR_MINUS)
        |-> !o_out_beat.last)
        else $error("sign character flagged as last");

    // Characters of one number advance one column a beat on the same line
    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_beat.last ##1 o_out_valid
        |-> o_out_beat.out_column == $past(o_out_beat.out_column) + 6'd1 &&
            o_out_beat.out_line == $past(o_out_beat.out_line))
        else $error("column did not advance by one");

endmodule

bind number_to_ascii_digits n2a_check u_n2a_check (.*);

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for number_to_ascii_digits
// Sends numbers in all four modes and checks every character beat
// (line, column, code, last flag) against a local model of the conversion.
// Directed cases cover the edge cases, random runs add more; idle gaps on input
// and stalls on output are random throughout, but for one stretch with neither.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_PRINTS = 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    n2a_pkg::t_in_beat in_beat = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    n2a_pkg::t_out_beat out_beat;

    // Characters still owed by the block, oldest first
    n2a_pkg::t_out_beat exp_chars[$];

    bit no_idle = 1'b0;
    int mismatches = 0;
    int numbers_sent = 0;
    int chars_checked = 0;
    int cycles = 0;

    number_to_ascii_digits DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_beat  (in_beat),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .o_out_beat (out_beat),
        .i_out_stall(out_stall)
    );

    // 20 ns clock
    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    // Expand one number into the characters it must produce
    function automatic void predict_chars(n2a_pkg::t_in_beat b);
        logic [5:0] max_dig;
        logic [5:0] n_dig;
        logic [31:0] mag;
        logic [31:0] scale;
        logic [5:0] col;
        logic [3:0] d;
        n2a_pkg::t_out_beat c;
        case (b.func)
            n2a_pkg::FUNC_HEX: max_dig = n2a_pkg::MAX_HEX;
            n2a_pkg::FUNC_BIN: max_dig = n2a_pkg::MAX_BIN;
            default:           max_dig = n2a_pkg::MAX_DEC;
        endcase
        n_dig = (b.digit_count == 6'd0) ? 6'd1 : b.digit_count;
        if (n_dig > max_dig) begin
            n_dig = max_dig;
        end
        mag = b.number;
        col = {1'b0, b.start_column};
        c.out_line = b.text_line;
        c.last = 1'b0;
        // Sign goes first, digits shift one column right
        if (b.func == n2a_pkg::FUNC_SDEC) begin
            c.out_column = col;
            c.char_code = b.number[31] ? n2a_pkg::CHAR_MINUS : n2a_pkg::CHAR_PLUS;
            if (b.number[31]) begin
                mag = -b.number;
            end
            exp_chars.push_back(c);
            col = col + 6'd1;
        end
        for (int pos = int'(n_dig) - 1; pos >= 0; pos--) begin
            case (b.func)
                n2a_pkg::FUNC_HEX: d = mag[4*pos +: 4];
                n2a_pkg::FUNC_BIN: d = {3'b000, mag[pos]};
                default: begin
                    scale = 32'd1;
                    repeat (pos) scale = scale * 32'd10;
                    d = 4'((mag / scale) % 32'd10);
                end
            endcase
            c.char_code = (d < 4'd10) ? n2a_pkg::CHAR_ZERO + 7'(d) :
                          n2a_pkg::CHAR_UPPER + 7'(d) - 7'd10;
            c.out_column = col;
            c.last = (pos == 0);
            exp_chars.push_back(c);
            col = col + 6'd1;
        end
    endfunction

    function automatic n2a_pkg::t_in_beat make_beat(logic [1:0] func, logic [31:0] number,
                                                    logic [5:0] count, logic [2:0] line,
                                                    logic [4:0] column);
        n2a_pkg::t_in_beat b;
        b.func = func;
        b.number = number;
        b.digit_count = count;
        b.text_line = line;
        b.start_column = column;
        return b;
    endfunction

    // Random number with bias toward the sign boundary, small and full values
    function automatic n2a_pkg::t_in_beat rand_beat();
        n2a_pkg::t_in_beat b;
        logic [5:0] top;
        b.func = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 5))
            0: b.number = $urandom_range(0, 20);
            1: b.number = 32'hFFFF_FFFF - $urandom_range(0, 20);
            2: b.number = 32'h8000_0000 + $urandom_range(0, 20) - 32'd10;
            3: b.number = $urandom_range(0, 99999);
            default: b.number = $urandom();
        endcase
        case (b.func)
            n2a_pkg::FUNC_HEX: top = n2a_pkg::MAX_HEX;
            n2a_pkg::FUNC_BIN: top = n2a_pkg::MAX_BIN;
            default:           top = n2a_pkg::MAX_DEC;
        endcase
        if ($urandom_range(0, 9) == 0) begin
            b.digit_count = 6'($urandom_range(0, 63));
        end else begin
            b.digit_count = 6'($urandom_range(1, top));
        end
        b.text_line = 3'($urandom_range(0, 7));
        b.start_column = 5'($urandom());
        return b;
    endfunction

    // Send one number; returns at the edge where it was accepted
    task automatic send_number(n2a_pkg::t_in_beat b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_chars(b);
        numbers_sent++;
    endtask

    task automatic report_mismatch(string what, int got, int want);
        if (mismatches < MAX_PRINTS) begin
            $display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
        end
        mismatches++;
    endtask

    // Check each accepted character against the oldest expectation
    always @(posedge clk) begin : check_chars
        n2a_pkg::t_out_beat want;
        if (rst_n && out_valid && !out_stall) begin
            if (exp_chars.size() == 0) begin
                report_mismatch("unexpected character, code", int'(out_beat.char_code), 0);
            end else begin
                want = exp_chars.pop_front();
                chars_checked++;
                if (out_beat.out_line !== want.out_line)
                    report_mismatch("line", int'(out_beat.out_line),
                                    int'(want.out_line));
                if (out_beat.out_column !== want.out_column)
                    report_mismatch("column", int'(out_beat.out_column),
                                    int'(want.out_column));
                if (out_beat.char_code !== want.char_code)
                    report_mismatch("char", int'(out_beat.char_code),
                                    int'(want.char_code));
                if (out_beat.last !== want.last)
                    report_mismatch("last", int'(out_beat.last), int'(want.last));
            end
        end
    end

    // Output backpressure: random stall bursts between ready stretches
    initial begin : drive_out_stall
        int n;
        forever begin
            @(posedge clk);
            n = pick_gap();
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(0, 6)) @(posedge clk);
        end
    end

    // Hard stop if the block hangs
    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // Every mode at its extremes, with line and column at both ends
    task automatic test_modes();
        send_number(make_beat(n2a_pkg::FUNC_UDEC, 32'd0, 6'd1, 3'd0, 5'd0));
        send_number(make_beat(n2a_pkg::FUNC_UDEC, 32'hFFFF_FFFF, 6'd10, 3'd7, 5'd31));
        send_number(make_beat(n2a_pkg::FUNC_UDEC, 32'd123456789, 6'd4, 3'd1, 5'd1));
        send_number(make_beat(n2a_pkg::FUNC_UDEC, 32'd42, 6'd10, 3'd4, 5'd16));
        send_number(make_beat(n2a_pkg::FUNC_SDEC, 32'd0, 6'd3, 3'd2, 5'd5));
        send_number(make_beat(n2a_pkg::FUNC_SDEC, 32'h8000_0000, 6'd10, 3'd3, 5'd31));
        send_number(make_beat(n2a_pkg::FUNC_SDEC, 32'hFFFF_FFFF, 6'd2, 3'd1, 5'd0));
        send_number(make_beat(n2a_pkg::FUNC_SDEC, 32'h7FFF_FFFF, 6'd10, 3'd7, 5'd10));
        send_number(make_beat(n2a_pkg::FUNC_HEX, 32'hDEAD_BEEF, 6'd8, 3'd5, 5'd2));
        send_number(make_beat(n2a_pkg::FUNC_HEX, 32'h0123_4567, 6'd3, 3'd6, 5'd30));
        send_number(make_beat(n2a_pkg::FUNC_HEX, 32'hABCD_EF09, 6'd8, 3'd0, 5'd31));
        send_number(make_beat(n2a_pkg::FUNC_BIN, 32'hFFFF_FFFF, 6'd32, 3'd7, 5'd31));
        send_number(make_beat(n2a_pkg::FUNC_BIN, 32'hA5A5_5A5A, 6'd32, 3'd1, 5'd0));
        send_number(make_beat(n2a_pkg::FUNC_BIN, 32'd5, 6'd4, 3'd2, 5'd8));
    endtask

    // Zero counts are raised to one, oversized counts are clamped
    task automatic test_count_limits();
        send_number(make_beat(n2a_pkg::FUNC_UDEC, 32'd987, 6'd0, 3'd1, 5'd1));
        send_number(make_beat(n2a_pkg::FUNC_UDEC, 32'd4000000000, 6'd63, 3'd2, 5'd3));
        send_number(make_beat(n2a_pkg::FUNC_SDEC, 32'hFFFF_FF85, 6'd0, 3'd3, 5'd4));
        send_number(make_beat(n2a_pkg::FUNC_SDEC, 32'd77, 6'd11, 3'd4, 5'd1));
        send_number(make_beat(n2a_pkg::FUNC_HEX, 32'hFEDC_BA98, 6'd0, 3'd1, 5'd7));
        send_number(make_beat(n2a_pkg::FUNC_HEX, 32'hFEDC_BA98, 6'd9, 3'd1, 5'd7));
        send_number(make_beat(n2a_pkg::FUNC_BIN, 32'h8000_0001, 6'd0, 3'd2, 5'd9));
        send_number(make_beat(n2a_pkg::FUNC_BIN, 32'h8000_0001, 6'd63, 3'd3, 5'd31));
    endtask

    task automatic test_random_mix(int n);
        repeat (n) send_number(rand_beat());
    endtask

    // Same mix with no input gaps and no output stalls
    task automatic test_back_to_back(int n);
        no_idle = 1'b1;
        repeat (n) send_number(rand_beat());
        no_idle = 1'b0;
    endtask

    initial begin : run_tests
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_modes();
        test_count_limits();
        test_random_mix(128);
        test_back_to_back(60);
        in_valid <= 1'b0;
        // Drain, then watch for stray characters
        while (exp_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("summary: %0d numbers in all four modes, %0d characters checked",
                 numbers_sent, chars_checked);
        $display("summary: %0d mismatches in %0d cycles", mismatches, cycles);
        if (mismatches == 0 && exp_chars.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
